[hdl/bps_pkg.sv]
// Shared codes, widths and interface types for the byte pattern search block.
package bps_pkg;

  localparam int PATTERN_MAX_DEF = 64;
  localparam int OFFSET_BITS_DEF = 48;

  // Port widths of the payload and configuration fields
  localparam int OFS_PORT_W = 48;
  localparam int PLEN_W     = 7;
  localparam int PIDX_W     = 6;
  localparam int MODE_W     = 2;
  localparam int CFG_ADDR_W = 1;

  localparam logic [MODE_W-1:0] MODE_LOAD = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FILE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_EOF  = 2'd2;

  localparam logic [CFG_ADDR_W-1:0] CFG_START_OFFSET   = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_PATTERN_LENGTH = 1'd1;

  // Broadcast from the front end to every cell
  typedef struct packed {
    logic       shift;
    logic       clear;
    logic [7:0] data;
  } bps_cell_ctl_t;

  // Transaction handed to the report stage
  typedef struct packed {
    logic valid;
    logic eof;
  } bps_push_t;

endpackage

[hdl/bps_cell.sv]
// One cell of the match chain: a pattern byte and its prefix-match bit.
module bps_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  logic [7:0]            load_byte_i,
  input  bps_pkg::bps_cell_ctl_t ctl_i,
  input  logic                  prev_match_i,
  output logic                  match_o
);
  import bps_pkg::*;

  logic [7:0] pat_q;
  logic       match_q, match_d;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pat_q <= load_byte_i;
    end
  end

  always_comb begin
    match_d = match_q;
    if (ctl_i.clear) begin
      match_d = 1'b0;
    end else if (ctl_i.shift) begin
      match_d = prev_match_i && (pat_q == ctl_i.data);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      match_q <= match_d;
    end
  end

  assign match_o = match_q;

endmodule

[hdl/bps_report.sv]
// Report stage: window offset check, first-match flag and output register.
module bps_report #(
  parameter int PATTERN_MAX = bps_pkg::PATTERN_MAX_DEF,
  parameter int OFFSET_BITS = bps_pkg::OFFSET_BITS_DEF,
  localparam int LEN_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bps_pkg::bps_push_t           push_i,
  input  logic [OFFSET_BITS-1:0]       pos_i,
  output logic                         ready_o,
  input  logic                         full_i,
  input  logic [LEN_W-1:0]             len_m1_i,
  input  logic [OFFSET_BITS-1:0]       start_offset_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         found_o,
  output logic [bps_pkg::OFS_PORT_W-1:0] match_offset_o
);
  import bps_pkg::*;

  localparam int WIDE_W = (OFFSET_BITS > OFS_PORT_W) ? OFFSET_BITS : OFS_PORT_W;

  logic                   s2_valid_q, s2_eof_q;
  logic [OFFSET_BITS-1:0] s2_pos_q;
  logic                   reported_q;
  logic                   out_valid_q, found_q;
  logic [OFS_PORT_W-1:0]  offset_q;

  logic [OFFSET_BITS-1:0] begin_ofs;
  logic [WIDE_W-1:0]      begin_wide;
  logic                   has_result, out_free, adv, take;

  assign begin_ofs  = s2_pos_q - OFFSET_BITS'(len_m1_i);
  assign begin_wide = WIDE_W'(begin_ofs);
  assign has_result = s2_valid_q && !reported_q &&
                      (s2_eof_q || (full_i && (begin_ofs >= start_offset_i)));
  assign out_free   = !out_valid_q || !out_stall_i;
  assign adv        = !has_result || out_free;
  assign ready_o    = !s2_valid_q || adv;
  assign take       = push_i.valid && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      s2_eof_q    <= 1'b0;
      reported_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ready_o) begin
        s2_valid_q <= take;
        s2_eof_q   <= push_i.eof;
      end
      if (s2_valid_q && adv) begin
        if (s2_eof_q) begin
          reported_q <= 1'b0;
        end else if (has_result) begin
          reported_q <= 1'b1;
        end
      end
      if (has_result && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s2_pos_q <= pos_i;
    end
    if (has_result && out_free) begin
      found_q  <= !s2_eof_q;
      offset_q <= s2_eof_q ? '0 : begin_wide[OFS_PORT_W-1:0];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign found_o        = found_q;
  assign match_offset_o = offset_q;

`ifndef SYNTHESIS
  a_s2_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && !adv) |=> (s2_valid_q && $stable(s2_pos_q) && $stable(s2_eof_q)))
    else $error("stalled report stage changed");
  a_found_sets_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (has_result && out_free && !s2_eof_q) |=> reported_q)
    else $error("found result did not set reported flag");
  a_eof_clears_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && s2_eof_q && adv) |=> !reported_q)
    else $error("end of file did not clear reported flag");
  a_notfound_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !found_q) |-> (offset_q == '0))
    else $error("not-found result with nonzero offset");
`endif

endmodule

[hdl/byte_pattern_search.sv]
// Byte pattern search: an accepted file byte or end of file is registered in the report
// stage, then in the output register, on its way to any result. Throughput one item per cycle
// while in_stall_o is low; the match chain shifts once per file byte. A stalled output
// stalls the input only when the waiting item would produce a result.
// Reset clears match bits, byte counter, reported flag and registers
// (start_offset 0, pattern_length 1); pattern bytes are undefined until loaded.
module byte_pattern_search #(
  parameter int PATTERN_MAX = bps_pkg::PATTERN_MAX_DEF,
  parameter int OFFSET_BITS = bps_pkg::OFFSET_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bps_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [bps_pkg::OFS_PORT_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [bps_pkg::MODE_W-1:0]     mode_i,
  input  logic [7:0]                     byte_value_i,
  input  logic [bps_pkg::PIDX_W-1:0]     pattern_index_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           found_o,
  output logic [bps_pkg::OFS_PORT_W-1:0] match_offset_o
);
  import bps_pkg::*;

  localparam int LEN_W  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int WIDE_W = (OFFSET_BITS > OFS_PORT_W) ? OFFSET_BITS : OFS_PORT_W;

  logic [OFFSET_BITS-1:0] start_q;
  logic [PLEN_W-1:0]      plen_q;
  logic [OFFSET_BITS-1:0] count_q, count_d;
  logic [WIDE_W-1:0]      cfg_wide;

  logic                   accept, rep_ready, file_ok, is_eof, is_load;
  logic [8:0]             len_m1_w;
  logic [LEN_W-1:0]       len_m1;
  logic [PATTERN_MAX-1:0] match_vec;
  logic [PATTERN_MAX-1:0] prev_vec;
  logic [PATTERN_MAX-1:0] load_sel;
  bps_cell_ctl_t          cell_ctl;
  bps_push_t              push;

  assign cfg_wide = WIDE_W'(cfg_wdata_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      plen_q  <= PLEN_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_START_OFFSET:   start_q <= cfg_wide[OFFSET_BITS-1:0];
        CFG_PATTERN_LENGTH: plen_q  <= cfg_wdata_i[PLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the length to 1..PATTERN_MAX
  always_comb begin
    if (plen_q == '0) begin
      len_m1_w = '0;
    end else if (9'(plen_q) > 9'(PATTERN_MAX)) begin
      len_m1_w = 9'(PATTERN_MAX - 1);
    end else begin
      len_m1_w = 9'(plen_q) - 9'd1;
    end
  end
  assign len_m1 = len_m1_w[LEN_W-1:0];

  assign in_stall_o = !rep_ready;
  assign accept     = in_valid_i && !in_stall_o;
  assign is_load    = accept && (mode_i == MODE_LOAD);
  assign file_ok    = accept && (mode_i == MODE_FILE) && !(&count_q);
  assign is_eof     = accept && (mode_i == MODE_EOF);

  always_comb begin
    count_d = count_q;
    if (is_eof) begin
      count_d = '0;
    end else if (file_ok) begin
      count_d = count_q + OFFSET_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign cell_ctl.shift = file_ok;
  assign cell_ctl.clear = is_eof;
  assign cell_ctl.data  = byte_value_i;

  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign prev_vec[i] = 1'b1;
    end else begin : g_link
      assign prev_vec[i] = match_vec[i-1];
    end
    assign load_sel[i] = is_load && (9'(pattern_index_i) == 9'(i));
    bps_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .load_i       (load_sel[i]),
      .load_byte_i  (byte_value_i),
      .ctl_i        (cell_ctl),
      .prev_match_i (prev_vec[i]),
      .match_o      (match_vec[i])
    );
  end

  assign push.valid = file_ok || is_eof;
  assign push.eof   = is_eof;

  bps_report #(
    .PATTERN_MAX (PATTERN_MAX),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_report (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .pos_i          (count_q),
    .ready_o        (rep_ready),
    .full_i         (match_vec[len_m1]),
    .len_m1_i       (len_m1),
    .start_offset_i (start_q),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .found_o        (found_o),
    .match_offset_o (match_offset_o)
  );

endmodule

[tb/tb_top.sv]
// Self-checking testbench for byte_pattern_search: directed and random file streams.
`timescale 1ns / 1ps

module tb_top;
  import bps_pkg::*;

  localparam logic [MODE_W-1:0] MODE_IDLE = 2'd3;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned DRAIN_CYCLES   = 4;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [7:0]        value;
    logic [PIDX_W-1:0] index;
  } search_item_t;

  typedef struct packed {
    logic                  found;
    logic [OFS_PORT_W-1:0] ofs;
  } search_report_t;

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  cfg_we_i        = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i      = '0;
  logic [OFS_PORT_W-1:0] cfg_wdata_i     = '0;
  logic                  in_valid_i      = 1'b0;
  logic                  in_stall_o;
  logic [MODE_W-1:0]     mode_i          = MODE_IDLE;
  logic [7:0]            byte_value_i    = '0;
  logic [PIDX_W-1:0]     pattern_index_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i     = 1'b0;
  logic                  found_o;
  logic [OFS_PORT_W-1:0] match_offset_o;

  byte_pattern_search DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .byte_value_i   (byte_value_i),
    .pattern_index_i(pattern_index_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .found_o        (found_o),
    .match_offset_o (match_offset_o)
  );

  search_item_t   feed_q [$];
  search_report_t reports_due [$];

  // Predicted block state
  logic [7:0]            pat_mem [64];
  logic [63:0]           prefix_hits = '0;
  logic [OFS_PORT_W-1:0] byte_cnt    = '0;
  logic                  reported    = 1'b0;
  logic [OFS_PORT_W-1:0] start_ofs   = '0;
  logic [PLEN_W-1:0]     plen        = 7'd1;

  // Stimulus side
  logic [7:0]  pat_img [64];
  logic [7:0]  alpha [4];
  bit          steady = 1'b0;
  int unsigned items_fed = 0;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  int unsigned gap_left = 0;
  int unsigned hold_left = 0;
  bit          in_hold;
  search_item_t next_item;
  search_report_t got;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned eff_len(input logic [PLEN_W-1:0] n);
    if (n == 0) return 1;
    if (n > 64) return 64;
    return 32'(n);
  endfunction

  task automatic advance_search(input search_item_t it);
    logic [OFS_PORT_W-1:0] pos;
    logic [OFS_PORT_W-1:0] win_start;
    int unsigned top;
    case (it.mode)
      MODE_LOAD: pat_mem[it.index] = it.value;
      MODE_FILE: begin
        if (byte_cnt != '1) begin
          pos = byte_cnt;
          prefix_hits = {prefix_hits[62:0], 1'b1};
          for (int i = 0; i < 64; i++) begin
            if (pat_mem[i] != it.value) prefix_hits[i] = 1'b0;
          end
          byte_cnt = byte_cnt + 1'b1;
          top = eff_len(plen) - 1;
          if (!reported && prefix_hits[top]) begin
            win_start = pos - top;
            if (win_start >= start_ofs) begin
              reported = 1'b1;
              reports_due.push_back('{found: 1'b1, ofs: win_start});
            end
          end
        end
      end
      MODE_EOF: begin
        if (!reported) reports_due.push_back('{found: 1'b0, ofs: '0});
        prefix_hits = '0;
        byte_cnt = '0;
        reported = 1'b0;
      end
      default: ;
    endcase
  endtask

  // Driver: one transaction per item from feed_q, random gap after each
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left = 0;
    end else begin
      in_hold = in_valid_i && in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        advance_search('{mode: mode_i, value: byte_value_i, index: pattern_index_i});
        gap_left = steady ? 0 : $urandom_range(0, 11);
      end
      if (!in_hold) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (feed_q.size() > 0) begin
          next_item = feed_q.pop_front();
          in_valid_i      <= 1'b1;
          mode_i          <= next_item.mode;
          byte_value_i    <= next_item.value;
          pattern_index_i <= next_item.index;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result against the oldest prediction, stall at random
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = '{found: found_o, ofs: match_offset_o};
        if (reports_due.size() == 0) begin
          $display("%0t unexpected result: expected none, actual found=%0b offset=%0d",
                   $realtime, got.found, got.ofs);
          mismatches++;
        end else begin
          if (got.found !== reports_due[0].found) begin
            $display("%0t found mismatch: expected %0b, actual %0b",
                     $realtime, reports_due[0].found, got.found);
            mismatches++;
          end
          if (got.ofs !== reports_due[0].ofs) begin
            $display("%0t match_offset mismatch: expected %0d, actual %0d",
                     $realtime, reports_due[0].ofs, got.ofs);
            mismatches++;
          end
          void'(reports_due.pop_front());
        end
        hold_left = steady ? 0 : $urandom_range(0, 11);
      end else if (hold_left > 0) begin
        hold_left--;
      end
      out_stall_i <= (hold_left != 0);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t watchdog: no transaction for %0d cycles", $realtime, idle_cycles);
        $display("status: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic push_item(input logic [MODE_W-1:0] md, input logic [7:0] val,
                           input logic [PIDX_W-1:0] idx);
    feed_q.push_back('{mode: md, value: val, index: idx});
    items_fed++;
  endtask

  task automatic load_byte(input int unsigned idx, input logic [7:0] val);
    pat_img[idx] = val;
    push_item(MODE_LOAD, val, PIDX_W'(idx));
  endtask

  task automatic file_byte(input logic [7:0] val);
    push_item(MODE_FILE, val, PIDX_W'($urandom_range(0, 63)));
  endtask

  task automatic end_file();
    push_item(MODE_EOF, 8'($urandom_range(0, 255)), PIDX_W'($urandom_range(0, 63)));
  endtask

  // Wait until every item is taken and every result is back, then let the pipe drain
  task automatic settle();
    while (feed_q.size() != 0 || in_valid_i || reports_due.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [OFS_PORT_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (addr == CFG_START_OFFSET) start_ofs = data;
    else plen = data[PLEN_W-1:0];
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] pick_byte();
    if ($urandom_range(0, 7) == 0) return 8'($urandom_range(0, 255));
    return alpha[$urandom_range(0, 3)];
  endfunction

  // One file: random bytes over a narrow alphabet, usually with a pattern copy
  // (sometimes cut short), sprinkled with idle and mid-file load transactions.
  task automatic feed_file(input int unsigned n_pat);
    logic [7:0]  fbytes [$];
    int unsigned n;
    int unsigned at;
    int unsigned cut;
    if ($urandom_range(0, 7) == 0) n = $urandom_range(0, n_pat - 1);
    else n = n_pat + $urandom_range(0, (n_pat > 16) ? 6 : 16);
    for (int i = 0; i < n; i++) fbytes.push_back(pick_byte());
    repeat ($urandom_range(1, 2)) begin
      if (n >= n_pat && $urandom_range(0, 3) != 0) begin
        at  = $urandom_range(0, n - n_pat);
        cut = ($urandom_range(0, 4) == 0) ? $urandom_range(1, n_pat) : n_pat;
        for (int i = 0; i < cut; i++) fbytes[at + i] = pat_img[i];
      end
    end
    foreach (fbytes[i]) begin
      case ($urandom_range(0, 39))
        0: push_item(MODE_IDLE, 8'($urandom_range(0, 255)), PIDX_W'($urandom_range(0, 63)));
        1: load_byte($urandom_range(0, 63), pick_byte());
        default: ;
      endcase
      file_byte(fbytes[i]);
    end
    end_file();
  endtask

  initial begin
    int unsigned base;
    int unsigned n_pat;
    int unsigned pick;
    logic [PLEN_W-1:0] len_w;
    logic [OFS_PORT_W-1:0] ofs_w;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Fill the whole pattern store so no unwritten entry is ever compared
    for (int i = 0; i < 64; i++) load_byte(i, 8'($urandom_range(0, 255)));
    pat_mem = pat_img;
    settle();

    // Length 1 after reset: first hit at offset 1, later hits stay quiet
    load_byte(0, 8'h00);
    load_byte(63, 8'hFF);
    file_byte(8'hFF);
    file_byte(8'h00);
    file_byte(8'h00);
    end_file();
    end_file();
    push_item(MODE_IDLE, 8'hFF, 6'h3F);
    settle();

    // Overlapping partial match, then a file shorter than the pattern
    write_reg(CFG_PATTERN_LENGTH, 48'd3);
    load_byte(1, 8'h11);
    load_byte(2, 8'h22);
    file_byte(8'h00); file_byte(8'h11); file_byte(8'h00); file_byte(8'h11);
    file_byte(8'h22);
    end_file();
    file_byte(8'h00); file_byte(8'h11);
    end_file();
    settle();

    // A match before start_offset is skipped
    write_reg(CFG_START_OFFSET, 48'd3);
    file_byte(8'h00); file_byte(8'h11); file_byte(8'h22);
    file_byte(8'h00); file_byte(8'h11); file_byte(8'h22);
    end_file();
    settle();

    // Load in the middle of a file affects only later bytes
    write_reg(CFG_START_OFFSET, 48'd0);
    file_byte(8'h00); file_byte(8'h11);
    load_byte(2, 8'h33);
    file_byte(8'h33);
    end_file();
    settle();

    // Length zero acts as one; highest start offset never matches
    write_reg(CFG_PATTERN_LENGTH, 48'd0);
    write_reg(CFG_START_OFFSET, {OFS_PORT_W{1'b1}});
    file_byte(8'h00); file_byte(8'h00);
    end_file();
    settle();

    // Oversized length clamps to the full pattern
    write_reg(CFG_PATTERN_LENGTH, 48'd127);
    write_reg(CFG_START_OFFSET, 48'd0);
    file_byte(8'h00);
    end_file();
    settle();

    base = items_fed;
    while (items_fed - base < 300) begin
      settle();
      steady = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 15);
      if (pick == 0) len_w = 7'd0;
      else if (pick == 1) len_w = 7'd64;
      else if (pick == 2) len_w = 7'($urandom_range(65, 127));
      else len_w = 7'($urandom_range(1, 8));
      pick = $urandom_range(0, 7);
      if (pick == 0) ofs_w = {OFS_PORT_W{1'b1}};
      else if (pick == 1) ofs_w = {16'($urandom), 32'($urandom)};
      else if (pick < 4) ofs_w = OFS_PORT_W'($urandom_range(1, 12));
      else ofs_w = '0;
      if ($urandom_range(0, 3) != 0) write_reg(CFG_PATTERN_LENGTH, OFS_PORT_W'(len_w));
      if ($urandom_range(0, 3) != 0) write_reg(CFG_START_OFFSET, ofs_w);
      n_pat = eff_len(plen);
      for (int i = 0; i < 4; i++) alpha[i] = 8'($urandom_range(0, 255));
      repeat ($urandom_range(1, n_pat)) begin
        load_byte($urandom_range(0, n_pat - 1), pick_byte());
      end
      if ($urandom_range(0, 3) == 0) load_byte($urandom_range(0, 63), pick_byte());
      repeat ((n_pat > 16) ? 1 : $urandom_range(1, 3)) feed_file(n_pat);
    end

    settle();
    repeat (8) @(negedge clk_i);
    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
